FILE: rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, constants and tables for the grid column raycaster.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int MAP_DIM_DEF    = 256;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_K     = 652032874;
    localparam int CW  = 46;    // cordic x/y width
    localparam int ZW  = 26;    // cordic angle accumulator, 2^-24 turn
    localparam int TW  = 18;    // trig results, signed Q16
    localparam int AIW = 29;    // atan2 operand width
    localparam int NW  = 18;    // crossing numerators
    localparam int DNW = 17;    // crossing denominators (|sin|, |cos|)
    localparam int QW  = NW + 16;
    localparam int CRW = 35;    // corrected distance

    typedef logic [4:0] t_op;
    localparam t_op OP_NONE      = 5'd0;
    localparam t_op OP_LOAD      = 5'd1;
    localparam t_op OP_SC_FH     = 5'd2;
    localparam t_op OP_AT_OFF    = 5'd3;
    localparam t_op OP_SC_RAY    = 5'd4;
    localparam t_op OP_SC_CD     = 5'd5;
    localparam t_op OP_WALK_INIT = 5'd6;
    localparam t_op OP_WALK_STEP = 5'd7;
    localparam t_op OP_DIV       = 5'd8;
    localparam t_op OP_CORR      = 5'd9;
    localparam t_op OP_SC_FV     = 5'd10;
    localparam t_op OP_ROW_INIT  = 5'd11;
    localparam t_op OP_AT_ROW    = 5'd12;
    localparam t_op OP_SC_ROW    = 5'd13;
    localparam t_op OP_PROD      = 5'd14;
    localparam t_op OP_SURF      = 5'd15;
    localparam t_op OP_NEXT      = 5'd16;

    localparam logic CM_SINCOS = 1'b0;
    localparam logic CM_ATAN   = 1'b1;

    localparam logic OPER_WRITE = 1'b0;

    localparam logic [2:0] CFG_COLS  = 3'd0;
    localparam logic [2:0] CFG_ROWS  = 3'd1;
    localparam logic [2:0] CFG_FOVH  = 3'd2;
    localparam logic [2:0] CFG_FOVV  = 3'd3;
    localparam logic [2:0] CFG_WALLH = 3'd4;
    localparam logic [2:0] CFG_EYEH  = 3'd5;
    localparam logic [2:0] CFG_PITCH = 3'd6;

    localparam logic [1:0] SURF_CEIL  = 2'd0;
    localparam logic [1:0] SURF_FLOOR = 2'd1;
    localparam logic [1:0] SURF_FB    = 2'd2;
    localparam logic [1:0] SURF_LR    = 2'd3;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
        logic div_done;
        logic wall;
        logic last;
    } t_stat;

    // arctangent of 2^-i in 2^-24 turn
    function automatic logic [21:0] atan_turn(input logic [3:0] i);
        logic [21:0] t;
        case (i)
            4'd0:  t = 22'd2097152;
            4'd1:  t = 22'd1238021;
            4'd2:  t = 22'd654136;
            4'd3:  t = 22'd332050;
            4'd4:  t = 22'd166669;
            4'd5:  t = 22'd83416;
            4'd6:  t = 22'd41718;
            4'd7:  t = 22'd20860;
            4'd8:  t = 22'd10430;
            4'd9:  t = 22'd5215;
            4'd10: t = 22'd2608;
            4'd11: t = 22'd1304;
            4'd12: t = 22'd652;
            4'd13: t = 22'd326;
            4'd14: t = 22'd163;
            default: t = 22'd81;
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/grc_cordic.sv
// ----------------------------------------------------------------------------
// grc_cordic
// Shared iterative CORDIC: sine/cosine of a turn fraction, or atan2 for x > 0.
// One micro-rotation per cycle.
// ----------------------------------------------------------------------------
module grc_cordic
    import grc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_mode,
    input  logic [15:0]           i_angle,
    input  logic signed [AIW-1:0] i_ay,
    input  logic signed [AIW-1:0] i_ax,
    output logic                  o_done,
    output logic signed [TW-1:0]  o_cos,
    output logic signed [TW-1:0]  o_sin,
    output logic signed [TW-1:0]  o_atan
);

    logic                 r_busy, r_done, r_mode, r_neg, r_exact, r_zero;
    logic [3:0]           r_i;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [TW-1:0] r_ec, r_es;

    logic signed [17:0]   z18;
    logic signed [ZW-1:0] z_ext;
    logic signed [AIW-1:0] ax_c;
    logic signed [CW-1:0] sx, sy, xr, yr;
    logic signed [ZW-1:0] t, zr;
    logic signed [TW-1:0] cr, sr;
    logic                 ccw;

    always_comb begin
        case (i_angle[15:14])
            2'd0:    z18 = $signed({2'b00, i_angle});
            2'd3:    z18 = $signed({2'b00, i_angle}) - 18'sd65536;
            default: z18 = $signed({2'b00, i_angle}) - 18'sd32768;
        endcase
        z_ext = ZW'(z18);
        ax_c  = (i_ax <= 0) ? AIW'(1) : i_ax;
    end

    assign sx  = r_x >>> r_i;
    assign sy  = r_y >>> r_i;
    assign t   = $signed(ZW'(atan_turn(r_i)));
    assign ccw = (r_mode == CM_SINCOS) ? !r_z[ZW-1] : !(r_y > 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_mode;
            if (i_mode == CM_SINCOS) begin
                r_x     <= CW'(CORDIC_K);
                r_y     <= '0;
                r_z     <= z_ext <<< 8;
                r_neg   <= (i_angle[15:14] == 2'd1) || (i_angle[15:14] == 2'd2);
                r_exact <= (i_angle[13:0] == 14'd0);
                r_zero  <= 1'b0;
                case (i_angle[15:14])
                    2'd0: begin r_ec <= TW'(65536);  r_es <= '0;            end
                    2'd1: begin r_ec <= '0;          r_es <= TW'(65536);    end
                    2'd2: begin r_ec <= -TW'(65536); r_es <= '0;            end
                    default: begin r_ec <= '0;       r_es <= -TW'(65536);   end
                endcase
            end else begin
                r_x     <= CW'(ax_c) <<< 16;
                r_y     <= CW'(i_ay) <<< 16;
                r_z     <= '0;
                r_neg   <= 1'b0;
                r_exact <= 1'b0;
                r_zero  <= (i_ay == 0);
            end
        end else if (r_busy) begin
            if (ccw) begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - t;
            end else begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + t;
            end
        end
    end

    assign xr = (r_x + CW'(8192)) >>> 14;
    assign yr = (r_y + CW'(8192)) >>> 14;
    assign zr = (r_z + ZW'(128)) >>> 8;
    assign cr = TW'(xr);
    assign sr = TW'(yr);

    assign o_done = r_done;
    assign o_cos  = r_exact ? r_ec : (r_neg ? -cr : cr);
    assign o_sin  = r_exact ? r_es : (r_neg ? -sr : sr);
    assign o_atan = r_zero ? '0 : TW'(zr);

endmodule

FILE: rtl/grc_div.sv
// ----------------------------------------------------------------------------
// grc_div
// Restoring divider for the hit distance: (num << 16) / den, one bit a cycle.
// ----------------------------------------------------------------------------
module grc_div
    import grc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_num,
    input  logic [DNW-1:0] i_den,
    output logic           o_done,
    output logic [QW-1:0]  o_quot
);

    logic           r_busy, r_done;
    logic [5:0]     r_cnt;
    logic [QW-1:0]  r_q;
    logic [DNW-1:0] r_rem, r_den;
    logic [DNW:0]   trial, diff;

    assign trial = {r_rem, r_q[QW-1]};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {i_num, 16'd0};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                r_rem <= diff[DNW-1:0];
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_rem <= trial[DNW-1:0];
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/grc_dp.sv
// ----------------------------------------------------------------------------
// grc_dp
// Datapath: configuration, wall map, angle set-up, grid walk, distance
// correction and per-row surface decision.
// ----------------------------------------------------------------------------
module grc_dp
    import grc_pkg::*;
#(
    parameter int MAP_DIM    = MAP_DIM_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_st,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_operation,
    input  logic [7:0]  i_cell_x,
    input  logic [7:0]  i_cell_y,
    input  logic        i_cell_is_wall,
    input  logic [7:0]  i_screen_column,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_heading,
    output logic [5:0]  o_row,
    output logic [1:0]  o_surface,
    output logic [15:0] o_wall_distance,
    output logic        o_last_row
);

    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int MW    = $clog2(DEPTH);
    localparam logic [15:0] ANG_MASK = 16'hFFFF << (16 - ANGLE_BITS);
    localparam logic signed [9:0] MAPD = 10'(MAP_DIM);

    function automatic logic [15:0] qang(input logic [15:0] a);
        return a & ANG_MASK;
    endfunction

    // configuration
    logic [7:0]  r_cols;
    logic [6:0]  r_rows;
    logic [14:0] r_fovh, r_fovv, r_pitch;
    logic [15:0] r_wallh, r_eyeh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= 8'd79;
            r_rows  <= 7'd23;
            r_fovh  <= 15'd16384;
            r_fovv  <= 15'd12000;
            r_wallh <= 16'd256;
            r_eyeh  <= 16'd128;
            r_pitch <= 15'd16384;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COLS:  r_cols  <= i_cfg_data[7:0];
                CFG_ROWS:  r_rows  <= i_cfg_data[6:0];
                CFG_FOVH:  r_fovh  <= i_cfg_data[14:0];
                CFG_FOVV:  r_fovv  <= i_cfg_data[14:0];
                CFG_WALLH: r_wallh <= i_cfg_data;
                CFG_EYEH:  r_eyeh  <= i_cfg_data;
                CFG_PITCH: r_pitch <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic [7:0] cols;
    logic [6:0] rows;
    assign cols = (r_cols == 8'd0) ? 8'd1 : r_cols;
    assign rows = (r_rows == 7'd0) ? 7'd1 :
                  ((r_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : r_rows);

    // item registers
    logic [7:0]  r_col;
    logic [15:0] r_px, r_py, r_hd, r_ray;
    logic signed [TW-1:0] r_c, r_s, r_cv, r_sv;
    logic [DNW-1:0] r_cd;

    // walk registers
    logic signed [9:0] r_cx, r_cy;
    logic [NW-1:0]  r_nx, r_ny, r_hitnum;
    logic [DNW-1:0] r_ac, r_as, r_hitden;
    logic           r_dxpos, r_dypos;
    logic [1:0]     r_side;
    logic           r_rd;

    // row registers
    logic [CRW-1:0]     r_corr;
    logic [5:0]         r_p;
    logic signed [53:0] r_prod;
    logic signed [34:0] r_hs, r_hws;
    logic               r_spz, r_spn;
    logic [5:0]         r_row;
    logic [1:0]         r_surf;
    logic [15:0]        r_dist;
    logic               r_last;

    // shared units
    logic                  cs_start, cs_mode;
    logic [15:0]           cs_angle;
    logic signed [AIW-1:0] cs_ay, cs_ax;
    logic                  cs_done;
    logic signed [TW-1:0]  cs_cos, cs_sin, cs_atan;
    logic                  dv_done;
    logic [QW-1:0]         dv_quot;

    grc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cs_start),
        .i_mode  (cs_mode),
        .i_angle (cs_angle),
        .i_ay    (cs_ay),
        .i_ax    (cs_ax),
        .o_done  (cs_done),
        .o_cos   (cs_cos),
        .o_sin   (cs_sin),
        .o_atan  (cs_atan)
    );

    grc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV),
        .i_num   (r_hitnum),
        .i_den   (r_hitden),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    // operand set-up for the cordic
    logic signed [10:0]    k_col;
    logic signed [7:0]     k_row;
    logic signed [AIW-1:0] y_off, x_off, y_row, x_row;
    logic [15:0]           ray_n;

    assign k_col = $signed({3'b000, cols}) - 11'sd1 - $signed({2'b00, r_col, 1'b0});
    assign k_row = $signed({1'b0, rows}) - 8'sd1 - $signed({1'b0, r_p, 1'b0});
    assign y_off = k_col * cs_sin;
    assign x_off = $signed({1'b0, cols}) * cs_cos;
    assign y_row = k_row * r_sv;
    assign x_row = $signed({1'b0, rows}) * r_cv;
    assign ray_n = qang(r_hd + cs_atan[15:0]);

    always_comb begin
        cs_start = 1'b0;
        cs_mode  = CM_SINCOS;
        cs_angle = '0;
        cs_ay    = y_off;
        cs_ax    = x_off;
        unique case (i_cmd.op)
            OP_SC_FH: begin
                cs_start = 1'b1;
                cs_angle = {2'b00, r_fovh[14:1]};
            end
            OP_AT_OFF: begin
                cs_start = 1'b1;
                cs_mode  = CM_ATAN;
            end
            OP_SC_RAY: begin
                cs_start = 1'b1;
                cs_angle = ray_n;
            end
            OP_SC_CD: begin
                cs_start = 1'b1;
                cs_angle = qang(r_ray - r_hd);
            end
            OP_SC_FV: begin
                cs_start = 1'b1;
                cs_angle = {2'b00, r_fovv[14:1]};
            end
            OP_AT_ROW: begin
                cs_start = 1'b1;
                cs_mode  = CM_ATAN;
                cs_ay    = y_row;
                cs_ax    = x_row;
            end
            OP_SC_ROW: begin
                cs_start = 1'b1;
                cs_angle = qang({1'b0, r_pitch} + cs_atan[15:0]);
            end
            default: ;
        endcase
    end

    // wall map
    logic          r_mem [DEPTH];
    logic          oob, we, wall, takey;
    logic [MW-1:0] raddr, waddr;
    logic [34:0]   py_ac, px_as;

    assign oob   = (r_cx < 0) || (r_cy < 0) || (r_cx >= MAPD) || (r_cy >= MAPD);
    assign raddr = oob ? '0 : (MW'(r_cy[8:0]) * MW'(MAP_DIM) + MW'(r_cx[8:0]));
    assign waddr = MW'(i_cell_y) * MW'(MAP_DIM) + MW'(i_cell_x);
    assign we    = (i_cmd.op == OP_LOAD) && (i_operation == OPER_WRITE) &&
                   ({1'b0, i_cell_x} < 9'(MAP_DIM)) && ({1'b0, i_cell_y} < 9'(MAP_DIM));

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= i_cell_is_wall;
        end
        r_rd <= r_mem[raddr];
    end

    assign wall  = oob || r_rd;
    assign py_ac = r_ny * r_ac;
    assign px_as = r_nx * r_as;
    assign takey = (r_as == '0) ? 1'b0 : ((r_ac == '0) ? 1'b1 : (py_ac < px_as));

    // walk start values, distance correction and height operands
    logic signed [TW-1:0] nc, ns;
    logic [DNW-1:0]       cd_clamp;
    logic [50:0]          corr_full;
    logic signed [35:0]   corr_s;
    logic signed [16:0]   h_s, hw_s;

    assign nc       = -r_c;
    assign ns       = -r_s;
    assign cd_clamp = cs_cos[TW-1] ? '0 : DNW'(cs_cos);
    assign corr_full = dv_quot * r_cd;
    assign corr_s   = $signed({1'b0, r_corr});
    assign h_s      = $signed({1'b0, r_eyeh});
    assign hw_s     = $signed({1'b0, r_eyeh}) - $signed({1'b0, r_wallh});

    // surface decision
    logic [1:0] surf;
    always_comb begin
        if (r_spz) begin
            if (r_prod == 0) begin
                surf = (r_eyeh >= r_wallh) ? SURF_CEIL :
                       ((r_eyeh == 16'd0) ? SURF_FLOOR : r_side);
            end else begin
                surf = (r_prod > 0) ? SURF_FLOOR : SURF_CEIL;
            end
        end else if (!r_spn) begin
            surf = (r_hws >= r_prod) ? SURF_CEIL : ((r_hs <= r_prod) ? SURF_FLOOR : r_side);
        end else begin
            surf = (r_hws <= r_prod) ? SURF_CEIL : ((r_hs >= r_prod) ? SURF_FLOOR : r_side);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_col <= i_screen_column;
                r_px  <= i_pos_x;
                r_py  <= i_pos_y;
                r_hd  <= i_heading;
            end
            OP_SC_RAY: r_ray <= ray_n;
            OP_SC_CD: begin
                r_c <= cs_cos;
                r_s <= cs_sin;
            end
            OP_WALK_INIT: begin
                r_cd     <= cd_clamp;
                r_cx     <= $signed({2'b00, r_px[15:8]});
                r_cy     <= $signed({2'b00, r_py[15:8]});
                r_ac     <= DNW'(r_c[TW-1] ? nc : r_c);
                r_as     <= DNW'(r_s[TW-1] ? ns : r_s);
                r_dxpos  <= (r_c > 0);
                r_dypos  <= (r_s > 0);
                r_nx     <= (r_c > 0) ? NW'(9'd256 - {1'b0, r_px[7:0]}) : NW'(r_px[7:0]);
                r_ny     <= (r_s > 0) ? NW'(9'd256 - {1'b0, r_py[7:0]}) : NW'(r_py[7:0]);
                r_hitnum <= '0;
                r_hitden <= DNW'(1);
                r_side   <= SURF_FB;
            end
            OP_WALK_STEP: begin
                if (!wall) begin
                    if (takey) begin
                        r_hitnum <= r_ny;
                        r_hitden <= r_as;
                        r_side   <= SURF_FB;
                        r_cy     <= r_dypos ? r_cy + 10'sd1 : r_cy - 10'sd1;
                        r_ny     <= r_ny + NW'(256);
                    end else begin
                        r_hitnum <= r_nx;
                        r_hitden <= r_ac;
                        r_side   <= SURF_LR;
                        r_cx     <= r_dxpos ? r_cx + 10'sd1 : r_cx - 10'sd1;
                        r_nx     <= r_nx + NW'(256);
                    end
                end
            end
            OP_CORR: r_corr <= corr_full[50:16];
            OP_ROW_INIT: begin
                r_cv <= cs_cos;
                r_sv <= cs_sin;
                r_p  <= '0;
            end
            OP_PROD: begin
                r_prod <= corr_s * cs_cos;
                r_hs   <= h_s * cs_sin;
                r_hws  <= hw_s * cs_sin;
                r_spz  <= (cs_sin == 0);
                r_spn  <= cs_sin[TW-1];
            end
            OP_SURF: begin
                r_row  <= r_p;
                r_surf <= surf;
                r_dist <= (r_corr > CRW'(16'hFFFF)) ? 16'hFFFF : r_corr[15:0];
                r_last <= (r_p == 6'(rows - 7'd1));
            end
            OP_NEXT: r_p <= r_p + 6'd1;
            default: ;
        endcase
    end

    assign o_st.cordic_done = cs_done;
    assign o_st.div_done    = dv_done;
    assign o_st.wall        = wall;
    assign o_st.last        = r_last;

    assign o_row           = r_row;
    assign o_surface       = r_surf;
    assign o_wall_distance = r_dist;
    assign o_last_row      = r_last;

endmodule

FILE: rtl/grc_ctrl.sv
// ----------------------------------------------------------------------------
// grc_ctrl
// Sequencer for one request: a write stores its cell from idle; a cast runs
// angle set-up, grid walk, divide, then one result per screen row.
// ----------------------------------------------------------------------------
module grc_ctrl
    import grc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_op,
    input  logic  i_out_stall,
    input  t_stat i_st,
    output t_cmd  o_cmd,
    output logic  o_in_stall,
    output logic  o_out_valid
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FH     = 5'd1;
    localparam logic [4:0] S_FH_W   = 5'd2;
    localparam logic [4:0] S_OFF    = 5'd3;
    localparam logic [4:0] S_OFF_W  = 5'd4;
    localparam logic [4:0] S_RAY    = 5'd5;
    localparam logic [4:0] S_RAY_W  = 5'd6;
    localparam logic [4:0] S_CD     = 5'd7;
    localparam logic [4:0] S_CD_W   = 5'd8;
    localparam logic [4:0] S_WINIT  = 5'd9;
    localparam logic [4:0] S_WRD    = 5'd10;
    localparam logic [4:0] S_WSTEP  = 5'd11;
    localparam logic [4:0] S_DIV    = 5'd12;
    localparam logic [4:0] S_DIV_W  = 5'd13;
    localparam logic [4:0] S_CORR   = 5'd14;
    localparam logic [4:0] S_FV     = 5'd15;
    localparam logic [4:0] S_FV_W   = 5'd16;
    localparam logic [4:0] S_RINIT  = 5'd17;
    localparam logic [4:0] S_ROW    = 5'd18;
    localparam logic [4:0] S_ROW_W  = 5'd19;
    localparam logic [4:0] S_PHI    = 5'd20;
    localparam logic [4:0] S_PHI_W  = 5'd21;
    localparam logic [4:0] S_PROD   = 5'd22;
    localparam logic [4:0] S_SURF   = 5'd23;
    localparam logic [4:0] S_OUT    = 5'd24;

    logic [4:0] r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_in_op != OPER_WRITE) n_state = S_FH;
                end
            end
            S_FH:    begin o_cmd.op = OP_SC_FH;  n_state = S_FH_W;  end
            S_FH_W:  if (i_st.cordic_done) n_state = S_OFF;
            S_OFF:   begin o_cmd.op = OP_AT_OFF; n_state = S_OFF_W; end
            S_OFF_W: if (i_st.cordic_done) n_state = S_RAY;
            S_RAY:   begin o_cmd.op = OP_SC_RAY; n_state = S_RAY_W; end
            S_RAY_W: if (i_st.cordic_done) n_state = S_CD;
            S_CD:    begin o_cmd.op = OP_SC_CD;  n_state = S_CD_W;  end
            S_CD_W:  if (i_st.cordic_done) n_state = S_WINIT;
            S_WINIT: begin o_cmd.op = OP_WALK_INIT; n_state = S_WRD; end
            S_WRD:   n_state = S_WSTEP;
            S_WSTEP: begin
                o_cmd.op = OP_WALK_STEP;
                n_state  = i_st.wall ? S_DIV : S_WRD;
            end
            S_DIV:   begin o_cmd.op = OP_DIV;    n_state = S_DIV_W; end
            S_DIV_W: if (i_st.div_done) n_state = S_CORR;
            S_CORR:  begin o_cmd.op = OP_CORR;   n_state = S_FV;    end
            S_FV:    begin o_cmd.op = OP_SC_FV;  n_state = S_FV_W;  end
            S_FV_W:  if (i_st.cordic_done) n_state = S_RINIT;
            S_RINIT: begin o_cmd.op = OP_ROW_INIT; n_state = S_ROW; end
            S_ROW:   begin o_cmd.op = OP_AT_ROW; n_state = S_ROW_W; end
            S_ROW_W: if (i_st.cordic_done) n_state = S_PHI;
            S_PHI:   begin o_cmd.op = OP_SC_ROW; n_state = S_PHI_W; end
            S_PHI_W: if (i_st.cordic_done) n_state = S_PROD;
            S_PROD:  begin o_cmd.op = OP_PROD;   n_state = S_SURF;  end
            S_SURF:  begin o_cmd.op = OP_SURF;   n_state = S_OUT;   end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (i_st.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.op = OP_NEXT;
                        n_state  = S_ROW;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

`ifndef SYNTHESIS
    a_cordic_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.cordic_done |-> (r_state == S_FH_W || r_state == S_OFF_W ||
                              r_state == S_RAY_W || r_state == S_CD_W ||
                              r_state == S_FV_W || r_state == S_ROW_W ||
                              r_state == S_PHI_W))
        else $error("cordic finished outside a wait state");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.div_done |-> (r_state == S_DIV_W))
        else $error("divider finished outside its wait state");

    a_out_after_surf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_SURF)
        else $error("result shown without a fresh surface decision");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LOAD) |-> (r_state == S_IDLE) && i_in_valid)
        else $error("request loaded while busy");
`endif

endmodule

FILE: rtl/grid_raycast_column.sv
// ----------------------------------------------------------------------------
// grid_raycast_column
// Column raycaster over a wall bit map, one result per screen row.
// ----------------------------------------------------------------------------
// A write request stores one map cell. A cast request runs four CORDIC
// set-up operations, starts the walk, visits grid cells (map read, then
// step, the wall cell included), divides and corrects the distance, runs
// the vertical set-up, then gives one result per screen row, each held by
// any output stall; the shared one-rotation-per-cycle CORDIC runs twice per
// row. Unwritten map cells read as undefined; write every cell a ray can reach
// before casting.
module grid_raycast_column
    import grc_pkg::*;
#(
    parameter int MAP_DIM    = MAP_DIM_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_cell_x,
    input  logic [7:0]  i_cell_y,
    input  logic        i_cell_is_wall,
    input  logic [7:0]  i_screen_column,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_heading,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_row,
    output logic [1:0]  o_surface,
    output logic [15:0] o_wall_distance,
    output logic        o_last_row,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat st;

    grc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_operation),
        .i_out_stall (i_out_stall),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    grc_dp #(
        .MAP_DIM    (MAP_DIM),
        .MAX_ROWS   (MAX_ROWS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_is_wall  (i_cell_is_wall),
        .i_screen_column (i_screen_column),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_heading       (i_heading),
        .o_row           (o_row),
        .o_surface       (o_surface),
        .o_wall_distance (o_wall_distance),
        .o_last_row      (o_last_row)
    );

    // register writes land at once; issue them only while no request is in flight
    assign o_cfg_ready = 1'b1;

endmodule
